[hdl/assert_macros.svh]
// Assertion macros shared by the detector modules.
// Depends on a clk and an active-low rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while in reset
`define GTD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked on every rising edge, off while in reset
`define GTD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[hdl/gtd_pkg.sv]
// Package for the Goertzel multi-tone detector: sizes, codes and types.
// No dependencies.
package gtd_pkg;
    localparam int NUM_TONES     = 4;
    localparam int POWER_HISTORY = 8;
    localparam int FRAC_BITS     = 10;

    localparam int SAMPLE_W  = 12;
    localparam int WIN_W     = 16;
    localparam int TONES_W   = 3;
    localparam int COEF_W    = 13;
    localparam int DATA_W    = 32;
    localparam int LEVEL_W   = 27;
    localparam int SIGLVL_W  = 20;
    localparam int TONE_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int LEVEL_SHIFT = 7;
    localparam int SLOT_W    = $clog2(POWER_HISTORY) < 1 ? 1 : $clog2(POWER_HISTORY);
    localparam int HIST_DEPTH = NUM_TONES * POWER_HISTORY;
    localparam int HIST_AW   = $clog2(HIST_DEPTH) < 1 ? 1 : $clog2(HIST_DEPTH);
    localparam logic [SAMPLE_W-1:0] MIDSCALE = 12'd2048;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(POWER_HISTORY - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW = 3'd0,
        CFG_TONES  = 3'd1,
        CFG_COEF0  = 3'd2,
        CFG_COEF1  = 3'd3,
        CFG_COEF2  = 3'd4,
        CFG_COEF3  = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SAMP_MUL,
        ST_SAMP_ADD,
        ST_PWR,
        ST_EMIT
    } gtd_state_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } smp_item_t;

    typedef logic signed [COEF_W-1:0] coef_t;
endpackage

[hdl/gtd_front.sv]
// Front part: accepts samples, marks the last sample of each window, queues them.
// Depends on gtd_pkg.
module gtd_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         sample_valid,
    output logic                         sample_stall,
    input  logic [gtd_pkg::SAMPLE_W-1:0] sample,
    input  logic [gtd_pkg::WIN_W-1:0]    window_length,
    output logic                         q_valid,
    output gtd_pkg::smp_item_t           q_item,
    input  logic                         q_take
);
    import gtd_pkg::*;

    smp_item_t       slot_reg [2];
    logic [1:0]      fill_reg, fill_next;
    logic [WIN_W-1:0] count_reg, count_next;
    logic            accept;
    logic [WIN_W:0]  count_inc;
    logic [WIN_W-1:0] win;
    smp_item_t       new_item;

    assign sample_stall = (fill_reg == 2'd2);
    assign accept       = sample_valid && !sample_stall;
    assign win          = (window_length == '0) ? WIN_W'(1) : window_length;
    assign count_inc    = {1'b0, count_reg} + (WIN_W+1)'(1);
    assign new_item.sample = sample;
    assign new_item.last   = (count_inc >= {1'b0, win});
    assign q_valid = (fill_reg != 2'd0);
    assign q_item  = slot_reg[0];

    always_comb
    begin
        fill_next = fill_reg + 2'(accept) - 2'(q_take);
        count_next = count_reg;
        if (accept)
        begin
            count_next = new_item.last ? '0 : count_inc[WIN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            fill_reg  <= fill_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (fill_reg == 2'd0 || (fill_reg == 2'd1 && q_take)))
        begin
            slot_reg[0] <= new_item;
        end
        else if (q_take)
        begin
            slot_reg[0] <= slot_reg[1];
        end
        if (accept && fill_reg == 2'd1 && !q_take)
        begin
            slot_reg[1] <= new_item;
        end
    end
endmodule

[hdl/gtd_back.sv]
// Back part: Goertzel recurrences, window powers, history rings and result output.
// Depends on gtd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module gtd_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  gtd_pkg::smp_item_t            q_item,
    output logic                          q_take,
    input  logic [gtd_pkg::TONES_W-1:0]   tones_in_use,
    input  gtd_pkg::coef_t                coef [gtd_pkg::NUM_TONES],
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [gtd_pkg::TONE_W-1:0]    tone_index,
    output logic signed [gtd_pkg::DATA_W-1:0] power_sum,
    output logic [gtd_pkg::SIGLVL_W-1:0]  signal_level,
    output logic                          last_tone
);
    import gtd_pkg::*;

    gtd_state_t state_reg, state_next;
    logic [TONE_W-1:0] tone_reg;
    logic [2:0]        phase_reg;
    smp_item_t         item_reg;
    logic signed [2*DATA_W-1:0] prod_reg;
    logic [DATA_W-1:0] tmp_reg, acc_reg;
    logic [DATA_W-1:0] prev1_reg [NUM_TONES];
    logic [DATA_W-1:0] prev2_reg [NUM_TONES];
    logic [DATA_W-1:0] sums_reg  [NUM_TONES];
    logic [DATA_W-1:0] hist_reg  [HIST_DEPTH];
    logic [LEVEL_W-1:0] level_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              full_reg;
    logic              out_valid_reg;

    logic [TONE_W-1:0] tone_last;
    logic              tone_done, out_free, full_next;
    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic [DATA_W-1:0] fx, pw, s1, s2;
    logic [HIST_AW-1:0] hidx;
    logic [SAMPLE_W-1:0] dev;

    always_comb
    begin
        if (tones_in_use == '0)
            tone_last = '0;
        else if (tones_in_use > TONES_W'(NUM_TONES))
            tone_last = TONE_W'(NUM_TONES - 1);
        else
            tone_last = TONE_W'(tones_in_use - TONES_W'(1));
    end

    assign tone_done = (tone_reg == tone_last);
    assign out_free  = !out_valid_reg || !result_stall;
    assign full_next = full_reg || (slot_reg == LAST_SLOT);
    assign fx  = prod_reg[FRAC_BITS+DATA_W-1:FRAC_BITS];
    assign s1  = prev1_reg[tone_reg];
    assign s2  = prev2_reg[tone_reg];
    assign pw  = acc_reg - fx;
    assign hidx = HIST_AW'(32'(tone_reg) * POWER_HISTORY + 32'(slot_reg));
    assign dev = (q_item.sample >= MIDSCALE) ? q_item.sample - MIDSCALE
                                             : MIDSCALE - q_item.sample;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (q_valid) state_next = ST_SAMP_MUL;
            ST_SAMP_MUL: state_next = ST_SAMP_ADD;
            ST_SAMP_ADD:
                if (tone_done)
                    state_next = item_reg.last ? ST_PWR : ST_IDLE;
                else
                    state_next = ST_SAMP_MUL;
            ST_PWR:
                if (phase_reg == 3'd4 && tone_done)
                    state_next = full_next ? ST_EMIT : ST_IDLE;
            ST_EMIT:     if (out_free && tone_done) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_take = 1'b0;
        mul_a  = DATA_W'(coef[tone_reg]);
        mul_b  = s1;
        case (state_reg)
            ST_IDLE: q_take = q_valid;
            ST_PWR:
                case (phase_reg)
                    3'd1:    begin mul_a = s2;      mul_b = s2; end
                    3'd2:    begin mul_a = s1;      mul_b = s1; end
                    3'd3:    begin mul_a = tmp_reg; mul_b = s2; end
                    default: begin mul_a = DATA_W'(coef[tone_reg]); mul_b = s1; end
                endcase
            default: q_take = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tone_reg      <= '0;
            phase_reg     <= '0;
            level_reg     <= '0;
            slot_reg      <= '0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_TONES; i++)
            begin
                prev1_reg[i] <= '0;
                prev2_reg[i] <= '0;
                sums_reg[i]  <= '0;
            end
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= (state_reg == ST_EMIT && out_free)
                             || (out_valid_reg && result_stall);
            case (state_reg)
                ST_IDLE:
                    if (q_valid)
                    begin
                        tone_reg  <= '0;
                        level_reg <= level_reg + LEVEL_W'(dev);
                    end
                ST_SAMP_ADD:
                begin
                    prev1_reg[tone_reg] <= DATA_W'(item_reg.sample) + fx - s2;
                    prev2_reg[tone_reg] <= s1;
                    tone_reg  <= tone_done ? '0 : tone_reg + TONE_W'(1);
                    phase_reg <= '0;
                end
                ST_PWR:
                    if (phase_reg == 3'd4)
                    begin
                        sums_reg[tone_reg] <= sums_reg[tone_reg] - hist_reg[hidx] + pw;
                        hist_reg[hidx]     <= pw;
                        phase_reg <= '0;
                        tone_reg  <= tone_done ? '0 : tone_reg + TONE_W'(1);
                        if (tone_done)
                        begin
                            full_reg <= full_next;
                            slot_reg <= (slot_reg == LAST_SLOT) ? '0 : slot_reg + SLOT_W'(1);
                            if (!full_next)
                            begin
                                level_reg <= '0;
                                for (int i = 0; i < NUM_TONES; i++)
                                begin
                                    prev1_reg[i] <= '0;
                                    prev2_reg[i] <= '0;
                                end
                            end
                        end
                    end
                    else
                    begin
                        phase_reg <= phase_reg + 3'd1;
                    end
                ST_EMIT:
                    if (out_free)
                    begin
                        tone_reg <= tone_reg + TONE_W'(1);
                        if (tone_done)
                        begin
                            level_reg <= '0;
                            for (int i = 0; i < NUM_TONES; i++)
                            begin
                                prev1_reg[i] <= '0;
                                prev2_reg[i] <= '0;
                            end
                        end
                    end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (q_take)
            item_reg <= q_item;
        if (state_reg == ST_PWR)
        begin
            if (phase_reg == 3'd1)
                tmp_reg <= fx;
            if (phase_reg == 3'd2)
                acc_reg <= fx;
            if (phase_reg == 3'd3)
                acc_reg <= acc_reg + fx;
        end
        if (state_reg == ST_EMIT && out_free)
        begin
            tone_index   <= tone_reg;
            power_sum    <= sums_reg[tone_reg];
            signal_level <= SIGLVL_W'(level_reg >> LEVEL_SHIFT);
            last_tone    <= tone_done;
        end
    end

    assign result_valid = out_valid_reg;

    `GTD_ASSERT_IMP(a_emit_full, state_reg == ST_EMIT, full_reg, "emit before ring full")
    `GTD_ASSERT(a_phase_range, phase_reg <= 3'd4, "power phase out of range")
    `GTD_ASSERT_IMP(a_out_from_emit, $rose(out_valid_reg), $past(state_reg == ST_EMIT),
        "result loaded outside emit")
endmodule

[hdl/goertzel_multi_tone_detector.sv]
// Goertzel multi-tone detector, top level: configuration registers, front and back.
// Depends on gtd_pkg, gtd_front and gtd_back.
// A sample leaves the queue, then for each tone in use takes a multiply on one shared
// 32x32 multiplier followed by the recurrence add; the last sample of a window then
// computes the power terms for each tone on the same multiplier and, once the ring is
// full, emits the results, one per cycle unless result_stall holds them. A two-entry
// queue takes samples while the back works.
module goertzel_multi_tone_detector (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [gtd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gtd_pkg::WIN_W-1:0]     cfg_data,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic [gtd_pkg::SAMPLE_W-1:0]  sample,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [gtd_pkg::TONE_W-1:0]    tone_index,
    output logic signed [gtd_pkg::DATA_W-1:0] power_sum,
    output logic [gtd_pkg::SIGLVL_W-1:0]  signal_level,
    output logic                          last_tone
);
    import gtd_pkg::*;

    logic [WIN_W-1:0]   window_length_reg;
    logic [TONES_W-1:0] tones_reg;
    coef_t              coef_reg [NUM_TONES];
    logic               q_valid, q_take;
    smp_item_t          q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WIN_W'(125);
            tones_reg         <= TONES_W'(2);
            for (int i = 0; i < NUM_TONES; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WINDOW: window_length_reg <= cfg_data;
                CFG_TONES:  tones_reg   <= cfg_data[TONES_W-1:0];
                CFG_COEF0:  coef_reg[0] <= cfg_data[COEF_W-1:0];
                CFG_COEF1:  coef_reg[1] <= cfg_data[COEF_W-1:0];
                CFG_COEF2:  coef_reg[2] <= cfg_data[COEF_W-1:0];
                CFG_COEF3:  coef_reg[3] <= cfg_data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    gtd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .sample        (sample),
        .window_length (window_length_reg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_take        (q_take)
    );

    gtd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_take       (q_take),
        .tones_in_use (tones_reg),
        .coef         (coef_reg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .tone_index   (tone_index),
        .power_sum    (power_sum),
        .signal_level (signal_level),
        .last_tone    (last_tone)
    );
endmodule

[verif/tb_top.sv]
// Self-checking bench for goertzel_multi_tone_detector: directed table, alternating run, then random samples.
// Depends on gtd_pkg and the detector RTL; predicts each window's tone power sums in place.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import gtd_pkg::*;

    typedef struct {
        logic [TONE_W-1:0]        tone;
        logic signed [DATA_W-1:0] psum;
        logic [SIGLVL_W-1:0]      level;
        logic                     last;
    } tone_res_t;

    typedef struct {
        logic [SAMPLE_W-1:0] smp;
        bit                  has_exp;
        logic [SIGLVL_W-1:0] exp_level;
    } dir_row_t;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WIN_W-1:0] cfg_data = '0;
    logic sample_valid = 0;
    logic sample_stall;
    logic [SAMPLE_W-1:0] sample = '0;
    logic result_valid;
    logic result_stall = 0;
    logic [TONE_W-1:0] tone_index;
    logic signed [DATA_W-1:0] power_sum;
    logic [SIGLVL_W-1:0] signal_level;
    logic last_tone;

    goertzel_multi_tone_detector uut (.*);

    always #5 clk = ~clk;

    // predictor state
    logic [WIN_W-1:0] win_len = 16'd125;
    logic [2:0] tones_cfg = 3'd2;
    logic [COEF_W-1:0] coef [NUM_TONES];
    logic [31:0] s1 [NUM_TONES];
    logic [31:0] s2 [NUM_TONES];
    logic [WIN_W-1:0] smp_cnt;
    logic [26:0] lvl_acc;
    logic [31:0] pw_hist [NUM_TONES][POWER_HISTORY];
    logic [31:0] pw_sum [NUM_TONES];
    int hslot;
    bit hfull;

    tone_res_t pending_res[$];
    int mismatches = 0;
    int idle_pct = 0, stall_pct = 0;
    bit hold_off = 0;
    bit done = 0;
    int quiet = 0;

    function automatic logic [31:0] qmul(logic [31:0] a, logic [31:0] b);
        logic signed [63:0] p;
        p = $signed(a) * $signed(b);
        return 32'(p >>> FRAC_BITS);
    endfunction

    task automatic predict_sample(logic [SAMPLE_W-1:0] x);
        int n;
        logic [31:0] w, c, pw;
        n = (tones_cfg == 0) ? 1 : (tones_cfg > NUM_TONES ? NUM_TONES : tones_cfg);
        w = (win_len == 0) ? 1 : win_len;
        lvl_acc = lvl_acc + 27'((x >= 2048) ? x - 2048 : 2048 - x);
        for (int t = 0; t < n; t++)
        begin
            c = {{19{coef[t][COEF_W-1]}}, coef[t]};
            pw = {20'd0, x} + qmul(c, s1[t]) - s2[t];
            s2[t] = s1[t];
            s1[t] = pw;
        end
        smp_cnt = smp_cnt + WIN_W'(1);
        if (smp_cnt < w)
            return;
        for (int t = 0; t < n; t++)
        begin
            c = {{19{coef[t][COEF_W-1]}}, coef[t]};
            pw = qmul(s2[t], s2[t]) + qmul(s1[t], s1[t]) - qmul(qmul(c, s1[t]), s2[t]);
            pw_sum[t] = pw_sum[t] - pw_hist[t][hslot] + pw;
            pw_hist[t][hslot] = pw;
        end
        if (hslot == POWER_HISTORY - 1)
            hfull = 1;
        if (hfull)
            for (int t = 0; t < n; t++)
                pending_res.push_back('{TONE_W'(t), pw_sum[t], lvl_acc[26:7], t == n - 1});
        hslot = (hslot + 1) % POWER_HISTORY;
        smp_cnt = 0;
        lvl_acc = 0;
        for (int t = 0; t < NUM_TONES; t++)
        begin
            s1[t] = 0;
            s2[t] = 0;
        end
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [WIN_W-1:0] val);
        @(negedge clk);
        cfg_we = 1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 0;
        case (idx)
            CFG_WINDOW: win_len = val;
            CFG_TONES:  tones_cfg = val[2:0];
            CFG_COEF0:  coef[0] = val[COEF_W-1:0];
            CFG_COEF1:  coef[1] = val[COEF_W-1:0];
            CFG_COEF2:  coef[2] = val[COEF_W-1:0];
            default:    coef[3] = val[COEF_W-1:0];
        endcase
    endtask

    task automatic settle();
        while (pending_res.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic send_beat(logic [SAMPLE_W-1:0] x);
        @(negedge clk);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
            @(negedge clk);
        sample_valid = 1;
        sample = x;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        predict_sample(x);
        @(negedge clk);
        sample_valid = 0;
    endtask

    task automatic set_phase(int p);
        idle_pct  = (p == 1) ? 67 : (p == 3) ? 38 : 0;
        stall_pct = (p == 2) ? 67 : (p == 3) ? 38 : 0;
    endtask

    always @(negedge clk)
        result_stall <= hold_off || (stall_pct != 0 && $urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        tone_res_t e;
        if (result_valid && !result_stall)
        begin
            if (pending_res.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result tone %0d sum %0d", tone_index, power_sum);
            end
            else
            begin
                e = pending_res.pop_front();
                if (e.tone !== tone_index || e.psum !== power_sum
                    || e.level !== signal_level || e.last !== last_tone)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 e.tone, e.psum, e.level, e.last,
                                 tone_index, power_sum, signal_level, last_tone);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall) || !rst_n
            || hold_off || done || (!sample_valid && pending_res.size() == 0))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > 20000)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    dir_row_t dir_rows[$];

    initial
    begin
        for (int t = 0; t < NUM_TONES; t++)
        begin
            coef[t] = 0;
            s1[t] = 0;
            s2[t] = 0;
            pw_sum[t] = 0;
            for (int k = 0; k < POWER_HISTORY; k++)
                pw_hist[t][k] = 0;
        end
        smp_cnt = 0;
        lvl_acc = 0;
        hslot = 0;
        hfull = 0;
        repeat (8) @(negedge clk);
        rst_n = 1;
        repeat (4) @(negedge clk);

        // one-sample windows so the ring fills within the table
        write_reg(CFG_WINDOW, 16'd0);
        write_reg(CFG_TONES, 3'd0);
        write_reg(CFG_COEF0, 16'h1800);
        for (int i = 0; i < 7; i++)
            dir_rows.push_back('{12'd2048, 0, '0});
        dir_rows.push_back('{12'd0, 1, 20'd16});
        dir_rows.push_back('{12'd4095, 1, 20'd15});
        dir_rows.push_back('{12'd2048, 1, 20'd0});
        dir_rows.push_back('{12'hAAA, 0, '0});
        dir_rows.push_back('{12'h555, 0, '0});
        foreach (dir_rows[i])
        begin
            send_beat(dir_rows[i].smp);
            if (dir_rows[i].has_exp && pending_res.size() != 0
                && pending_res[$].level !== dir_rows[i].exp_level)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("table row %0d level exp %0d got %0d", i,
                             dir_rows[i].exp_level, pending_res[$].level);
            end
        end
        settle();
        write_reg(CFG_TONES, 3'd7);
        write_reg(CFG_COEF1, 16'h0800);
        write_reg(CFG_COEF2, 16'h1F00);
        write_reg(CFG_COEF3, 16'h0000);
        write_reg(CFG_WINDOW, 16'd2);
        for (int i = 0; i < 10; i++)
            send_beat(i[0] ? 12'hFFF : 12'h000);
        settle();

        for (int p = 0; p < 4; p++)
        begin
            set_phase(p);
            write_reg(CFG_WINDOW, 16'($urandom_range(1, 6)));
            write_reg(CFG_TONES, 3'($urandom_range(1, 4)));
            write_reg(CFG_COEF0, 16'($urandom_range(0, 4096) - 2048));
            write_reg(CFG_COEF1, 16'($urandom_range(0, 4096) - 2048));
            write_reg(CFG_COEF2, (p == 1) ? 16'h1800 : 16'($urandom_range(0, 4096) - 2048));
            write_reg(CFG_COEF3, (p == 2) ? 16'h0800 : 16'($urandom_range(0, 4096) - 2048));
            if (p == 0)
            begin
                fork
                    begin
                        hold_off = 1;
                        repeat (400) @(negedge clk);
                        hold_off = 0;
                    end
                join_none
            end
            for (int i = 0; i < 70; i++)
                send_beat(12'($urandom));
            settle();
        end

        done = 1;
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

[files.f]
+incdir+hdl
hdl/gtd_pkg.sv
hdl/gtd_front.sv
hdl/gtd_back.sv
hdl/goertzel_multi_tone_detector.sv
verif/tb_top.sv
